### rtl/core/dwr_pkg.sv
// Package with the types and constants shared by the deque with rotate.
`timescale 1ns / 1ps

package dwr_pkg;

  // Payload widths fixed by the command and result formats.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned AMT_W     = 32;
  localparam int unsigned AMT_CNT_W = 5;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STAT_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_ROTATE     = 3'd6,
    CMD_SIZE       = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ROT,
    S_RESP
  } state_e;

endpackage

### rtl/core/dwr_rem_unit.sv
// Bit-serial remainder unit: magnitude of the rotation amount modulo the element count.
`timescale 1ns / 1ps

module dwr_rem_unit #(
  parameter int unsigned CNT_W = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dwr_pkg::AMT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic [CNT_W-1:0]          rem_o
);
  import dwr_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [AMT_CNT_W-1:0] bit_q;
  logic [AMT_W-1:0]     shift_q;
  logic [CNT_W-1:0]     div_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W:0]       trial;
  logic                 fits;
  logic [CNT_W-1:0]     rem_d;

  // One restoring step per cycle, dividend bits taken MSB first.
  always_comb begin
    trial = {rem_q, shift_q[AMT_W-1]};
    fits  = trial >= {1'b0, div_q};
    if (fits) begin
      rem_d = CNT_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = CNT_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else if (busy_q) begin
      bit_q <= bit_q + AMT_CNT_W'(1);
      if (bit_q == AMT_CNT_W'(AMT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      div_q   <= divisor_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[AMT_W-2:0], 1'b0};
      rem_q   <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("remainder unit restarted while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("remainder done held past one cycle");

endmodule

### rtl/core/deque_with_rotate_top.sv
// Top level of the bounded double-ended queue with rotation.
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+-----------------------------------------
// in      | input     | in_valid_i / in_ready_o | command_i, data_in_i, rotate_amount_i
// out     | output    | out_valid_o/out_ready_i | data_out_o, status_o, count_o
//
// Push, pop, peek, size and failing commands are accepted (store write or read issue), then
// pass through the response state, which loads the output register.
// Rotate on a non-empty queue: accept, the bit-serial remainder unit finds steps = rotation
// mod count, the copy state moves one element a cycle and drains, then the response; with
// steps 0 or a full store only the head moves and the copy is skipped.
// Reset clears head, count, state and output valid, not the store. Input is ready only in
// idle; a result waits in the response state while an earlier one sits unaccepted.
module deque_with_rotate_top #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dwr_pkg::CMD_W-1:0]  command_i,
  input  logic [dwr_pkg::DATA_W-1:0] data_in_i,
  input  logic signed [dwr_pkg::AMT_W-1:0] rotate_amount_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dwr_pkg::DATA_W-1:0] data_out_o,
  output logic [dwr_pkg::STAT_W-1:0] status_o,
  output logic [CNT_W-1:0]           count_o
);
  import dwr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = CNT_W + 1;

  // Circular slot arithmetic: base + offset modulo DEPTH, offset never above DEPTH.
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [CNT_W-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Control state.
  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] left_q, left_d;

  // Per-command bookkeeping.
  status_e          res_status_q, res_status_d;
  logic             res_mem_q, res_mem_d;
  logic             amt_neg_q, amt_neg_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;

  // Output register.
  logic [DATA_W-1:0] out_data_q;
  logic [STAT_W-1:0] out_status_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_load;

  // Element store.
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] mem_rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [WIDTH-1:0] mem_wdata;

  // Remainder unit.
  logic             div_start;
  logic             div_done;
  logic [CNT_W-1:0] div_rem;
  logic [AMT_W-1:0] amt_mag;

  // Derived values.
  cmd_e                    cmd;
  logic                    in_accept;
  logic                    full, empty;
  logic [AW-1:0]           head_dec;
  logic [CNT_W-1:0]        steps;
  logic [WIDTH+DATA_W-1:0] in_ext;
  logic [WIDTH+DATA_W-1:0] rd_ext;
  logic [WIDTH-1:0]        word_in;

  assign cmd        = cmd_e'(command_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign head_dec   = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  // Keep only the low WIDTH bits of a pushed word; zero-extend words on the way out.
  assign in_ext  = {{WIDTH{1'b0}}, data_in_i};
  assign word_in = in_ext[WIDTH-1:0];
  assign rd_ext  = {{DATA_W{1'b0}}, mem_rdata_q};

  // Magnitude of the amount; the most negative value maps to 2^31 as unsigned.
  assign amt_mag = rotate_amount_i[AMT_W-1] ? (~rotate_amount_i + AMT_W'(1))
                                            : rotate_amount_i;

  // C truncating modulo keeps the sign of the amount; fold it into a forward count.
  always_comb begin
    if (div_rem == '0) begin
      steps = '0;
    end else if (amt_neg_q) begin
      steps = count_q - div_rem;
    end else begin
      steps = div_rem;
    end
  end

  dwr_rem_unit #(
    .CNT_W (CNT_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (amt_mag),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Next state, store access and bookkeeping.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    pend_d       = pend_q;
    left_d       = left_q;
    res_status_d = res_status_q;
    res_mem_d    = res_mem_q;
    amt_neg_d    = amt_neg_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    pend_addr_d  = pend_addr_q;
    mem_we       = 1'b0;
    mem_waddr    = pend_addr_q;
    mem_wdata    = mem_rdata_q;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_q;
    div_start    = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d      = S_RESP;
          res_status_d = STAT_OK;
          res_mem_d    = 1'b0;
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (full) begin
                res_status_d = STAT_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = word_in;
                count_d   = count_q + CNT_W'(1);
                if (cmd == CMD_PUSH_FRONT) begin
                  mem_waddr = head_dec;
                  head_d    = head_dec;
                end else begin
                  mem_waddr = slot_add(head_q, count_q);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
              if (empty) begin
                res_status_d = STAT_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                res_mem_d = 1'b1;
                if (cmd inside {CMD_POP_FRONT, CMD_PEEK_FRONT}) begin
                  mem_raddr = head_q;
                end else begin
                  mem_raddr = slot_add(head_q, count_q - CNT_W'(1));
                end
                if (cmd == CMD_POP_FRONT) begin
                  head_d  = slot_add(head_q, CNT_W'(1));
                  count_d = count_q - CNT_W'(1);
                end else if (cmd == CMD_POP_BACK) begin
                  count_d = count_q - CNT_W'(1);
                end
              end
            end
            CMD_ROTATE: begin
              if (!empty) begin
                div_start = 1'b1;
                amt_neg_d = rotate_amount_i[AMT_W-1];
                state_d   = S_DIV;
              end
            end
            default: begin
              // Size: report the count only.
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          if (steps == '0 || full) begin
            // A full ring rotates by moving the head alone.
            head_d  = slot_add(head_q, steps);
            state_d = S_RESP;
          end else begin
            rd_ptr_d = head_q;
            wr_ptr_d = slot_add(head_q, count_q);
            left_d   = steps;
            pend_d   = 1'b0;
            state_d  = S_ROT;
          end
        end
      end

      S_ROT: begin
        // Drain the copy read in the previous cycle.
        if (pend_q) begin
          mem_we = 1'b1;
        end
        if (left_q != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = rd_ptr_q;
          rd_ptr_d    = slot_add(rd_ptr_q, CNT_W'(1));
          pend_addr_d = wr_ptr_q;
          wr_ptr_d    = slot_add(wr_ptr_q, CNT_W'(1));
          left_d      = left_q - CNT_W'(1);
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            head_d  = rd_ptr_q;
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      left_q      <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_mem_q    <= res_mem_d;
    amt_neg_q    <= amt_neg_d;
    rd_ptr_q     <= rd_ptr_d;
    wr_ptr_q     <= wr_ptr_d;
    pend_addr_q  <= pend_addr_d;
    if (out_load) begin
      out_data_q   <= res_mem_q ? rd_ext[DATA_W-1:0] : '0;
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
    end
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_count_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(in_accept))
    else $error("element count changed without an accepted beat");

  a_rot_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT && pend_q && mem_re) |-> (pend_addr_q != rd_ptr_q))
    else $error("rotation copy reads the slot it writes");

endmodule

### tb/tb.sv
// Testbench for the deque with rotate: directed and random commands against a shadow deque.
`timescale 1ns / 1ps

module tb;
  import dwr_pkg::*;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned WIDTH          = 32;
  localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
  localparam int unsigned NUM_ITEMS      = 1100;
  // Long receiver hold-off, well past the time the block needs to fill up and stall.
  localparam int unsigned RX_HOLD_CYCLES = 300;
  // Settle past the longest rotation at the end.
  localparam int unsigned SETTLE_CYCLES  = 150;
  // No beat on either side for this long means the block is stuck. The longest legal quiet
  // stretch is the receiver hold-off plus one rotation, far below this.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic signed [AMT_W-1:0] AMT_MOST_NEG = 32'sh8000_0000;
  localparam logic signed [AMT_W-1:0] AMT_MOST_POS = 32'sh7FFF_FFFF;

  // One expected result beat.
  typedef struct {
    logic [DATA_W-1:0] data;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } deque_resp_t;

  // Shadow copy of the deque. Every accepted command beat is applied here and its expected
  // result queued; every result beat from the block is compared with the oldest one.
  class deque_shadow;
    int unsigned       capacity;
    logic [DATA_W-1:0] words[$];
    deque_resp_t       awaited[$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       cmd_seen[8];
    int unsigned       overflows;
    int unsigned       underflows;
    int unsigned       rotations_moved;
    int unsigned       peak_fill;

    function new(int unsigned depth);
      capacity = depth;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] MISMATCH %s", $time, msg);
      end else if (mismatches == MAX_REPORTS + 1) begin
        $display("further mismatches are counted only");
      end
    endfunction

    function void note_command(cmd_e cmd, logic [DATA_W-1:0] word,
                               logic signed [AMT_W-1:0] amount);
      deque_resp_t r;
      longint      fill;
      longint      rem;
      longint      steps;
      r.data   = '0;
      r.status = STAT_OK;
      cmd_seen[int'(cmd)]++;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (words.size() >= capacity) begin
            r.status = STAT_OVERFLOW;
          end else if (cmd == CMD_PUSH_FRONT) begin
            words.push_front(word);
          end else begin
            words.push_back(word);
          end
        end
        CMD_ROTATE: begin
          if (words.size() != 0) begin
            fill  = words.size();
            // signed % truncates toward zero, so rem carries the sign of the amount
            rem   = longint'(amount) % fill;
            steps = (rem < 0) ? rem + fill : rem;
            if (steps != 0) rotations_moved++;
            repeat (steps) words.push_back(words.pop_front());
          end
        end
        CMD_SIZE: ;
        default: begin
          // pops and peeks
          if (words.size() == 0) begin
            r.status = STAT_UNDERFLOW;
          end else if (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT) begin
            r.data = words[0];
            if (cmd == CMD_POP_FRONT) void'(words.pop_front());
          end else begin
            r.data = words[$];
            if (cmd == CMD_POP_BACK) void'(words.pop_back());
          end
        end
      endcase
      if (r.status == STAT_OVERFLOW) overflows++;
      if (r.status == STAT_UNDERFLOW) underflows++;
      if (words.size() > peak_fill) peak_fill = words.size();
      r.count = CNT_W'(words.size());
      awaited.push_back(r);
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic [STAT_W-1:0] status,
                               logic [CNT_W-1:0] count);
      deque_resp_t e;
      results_seen++;
      if (awaited.size() == 0) begin
        flag($sformatf("result beat with nothing outstanding: data=%h status=%0d count=%0d",
                       data, status, count));
        return;
      end
      e = awaited.pop_front();
      if (data !== e.data || status !== e.status || count !== e.count) begin
        flag($sformatf({"result %0d: expected data=%h status=%s count=%0d, ",
                        "got data=%h status=%0d count=%0d"},
                       results_seen, e.data, e.status.name(), e.count, data, status, count));
      end
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    in_valid_i      = 1'b0;
  logic [CMD_W-1:0]        command_i       = '0;
  logic [DATA_W-1:0]       data_in_i       = '0;
  logic signed [AMT_W-1:0] rotate_amount_i = '0;
  logic                    out_ready_i     = 1'b0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic [DATA_W-1:0]       data_out_o;
  logic [STAT_W-1:0]       status_o;
  logic [CNT_W-1:0]        count_o;

  deque_shadow shadow;
  bit          rx_hold_req = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  deque_with_rotate_top #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .data_in_i      (data_in_i),
    .rotate_amount_i(rotate_amount_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_out_o     (data_out_o),
    .status_o       (status_o),
    .count_o        (count_o)
  );

  // Sender idle draw: none in a burst stretch, else a uniformly random idle gap.
  function automatic int unsigned sender_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // Offer one command beat after an idle gap and hold it until accepted. Valid is only
  // lowered when a gap follows, so back-to-back beats keep it high through the edge.
  // Apply the beat to the shadow right at the accepting edge.
  task automatic send_command(cmd_e cmd, logic [DATA_W-1:0] word,
                              logic signed [AMT_W-1:0] amount, int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    data_in_i       <= word;
    rotate_amount_i <= amount;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.note_command(cmd, word, amount);
    items_sent++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (shadow.awaited.size() != 0);
  endtask

  // Weighted command draw; peeks, rotations and sizes keep a fixed share.
  function automatic cmd_e pick_command(int unsigned push_w, int unsigned pop_w);
    int unsigned roll;
    roll = $urandom_range(0, push_w + pop_w + 29);
    if (roll < push_w) return ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    roll -= push_w;
    if (roll < pop_w) return ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
    roll -= pop_w;
    if (roll < 10) return ($urandom_range(0, 1) != 0) ? CMD_PEEK_FRONT : CMD_PEEK_BACK;
    if (roll < 22) return CMD_ROTATE;
    return CMD_SIZE;
  endfunction

  // Rotation amounts: mostly small of either sign, some full-range words, the extremes,
  // and whole multiples of the current fill (which must leave the order alone).
  function automatic logic signed [AMT_W-1:0] pick_rotation();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return int'($urandom_range(0, 140)) - 70;
      5, 6:          return $urandom;
      7: begin
        case ($urandom_range(0, 3))
          0:       return AMT_MOST_NEG;
          1:       return AMT_MOST_POS;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: begin
        k = int'($urandom_range(0, 6)) - 3;
        return k * int'(shadow.words.size());
      end
    endcase
  endfunction

  // One stretch of random commands with a given push/pop bias. Non-push beats still carry
  // random data and every beat random rotation bits, so unused fields get exercised too.
  task automatic random_phase(int unsigned len, int unsigned push_w, int unsigned pop_w,
                              bit force_burst);
    bit                      burst;
    cmd_e                    cmd;
    logic signed [AMT_W-1:0] amount;
    burst = force_burst || ($urandom_range(0, 3) == 0);
    repeat (len) begin
      cmd    = pick_command(push_w, pop_w);
      amount = (cmd == CMD_ROTATE) ? pick_rotation() : $urandom;
      send_command(cmd, $urandom, amount, sender_gap(burst));
    end
  endtask

  initial begin : stimulus
    bit burst;
    shadow = new(DEPTH);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command on an empty deque, including a rotation by the most negative
    // amount, then four words with all-ones, all-zero and alternating patterns at both ends.
    send_command(CMD_SIZE,       '1,           '0,           sender_gap(0));
    send_command(CMD_POP_FRONT,  '1,           '1,           sender_gap(0));
    send_command(CMD_POP_BACK,   '0,           '0,           sender_gap(0));
    send_command(CMD_PEEK_FRONT, '1,           '0,           sender_gap(0));
    send_command(CMD_PEEK_BACK,  '0,           '1,           sender_gap(0));
    send_command(CMD_ROTATE,     '0,           AMT_MOST_NEG, sender_gap(0));
    send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF, '0,          sender_gap(0));
    send_command(CMD_PUSH_BACK,  32'h0000_0000, '1,          sender_gap(0));
    send_command(CMD_PUSH_FRONT, 32'hA5A5_A5A5, '0,          sender_gap(0));
    send_command(CMD_PUSH_BACK,  32'h5A5A_5A5A, '0,          sender_gap(0));
    send_command(CMD_PEEK_FRONT, '0,           '0,           sender_gap(0));
    send_command(CMD_PEEK_BACK,  '0,           '0,           sender_gap(0));
    // Rotations on four elements: one each way, the positive extreme, the negative extreme
    // and minus eight (both multiples of four, so no change), and zero.
    send_command(CMD_ROTATE,     '0,           32'sd1,       sender_gap(0));
    send_command(CMD_ROTATE,     '0,           -32'sd1,      sender_gap(0));
    send_command(CMD_ROTATE,     '0,           AMT_MOST_POS, sender_gap(0));
    send_command(CMD_ROTATE,     '0,           AMT_MOST_NEG, sender_gap(0));
    send_command(CMD_ROTATE,     '0,           -32'sd8,      sender_gap(0));
    send_command(CMD_ROTATE,     '0,           '0,           sender_gap(0));
    send_command(CMD_SIZE,       '0,           '0,           sender_gap(0));
    // Drain from both ends, then underflow at each end.
    send_command(CMD_POP_FRONT,  '0,           '0,           sender_gap(0));
    send_command(CMD_POP_BACK,   '0,           '0,           sender_gap(0));
    send_command(CMD_POP_BACK,   '0,           '0,           sender_gap(0));
    send_command(CMD_POP_FRONT,  '0,           '0,           sender_gap(0));
    send_command(CMD_POP_FRONT,  '0,           '0,           sender_gap(0));
    send_command(CMD_POP_BACK,   '0,           '0,           sender_gap(0));
    pause_until_drained();

    // Fill from empty to full with random words at random ends, and push past full so the
    // overflow path is hit.
    burst = ($urandom_range(0, 1) != 0);
    repeat (DEPTH + 4) begin
      send_command(($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                   $urandom, $urandom, sender_gap(burst));
    end
    // Work around the full mark: long rotations, peeks, pushes that overflow.
    random_phase(40, 60, 10, 1'b0);
    // Drain to empty from random ends, then hammer the empty deque.
    while (shadow.words.size() != 0) begin
      send_command(($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK,
                   $urandom, $urandom, sender_gap(burst));
    end
    random_phase(20, 5, 60, 1'b0);

    // Back-pressure: the receiver holds off for a long stretch while commands keep coming
    // back to back, so the block's result slots fill and it stalls its input.
    rx_hold_req = 1'b1;
    random_phase(60, 40, 30, 1'b1);
    pause_until_drained();

    // Random stretches with a push, pop or even bias, sometimes pausing until drained.
    while (items_sent < NUM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       random_phase($urandom_range(30, 80), 60, 20, 1'b0);
        1:       random_phase($urandom_range(30, 80), 20, 60, 1'b0);
        default: random_phase($urandom_range(30, 80), 35, 35, 1'b0);
      endcase
      if ($urandom_range(0, 3) == 0) pause_until_drained();
    end

    pause_until_drained();
    // Anything that shows up now has no command behind it and is flagged by the check.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display({"Ran %0d commands: push %0d/%0d, pop %0d/%0d, peek %0d/%0d, ",
              "rotate %0d, size %0d; %0d results checked"},
             items_sent, shadow.cmd_seen[CMD_PUSH_FRONT], shadow.cmd_seen[CMD_PUSH_BACK],
             shadow.cmd_seen[CMD_POP_FRONT], shadow.cmd_seen[CMD_POP_BACK],
             shadow.cmd_seen[CMD_PEEK_FRONT], shadow.cmd_seen[CMD_PEEK_BACK],
             shadow.cmd_seen[CMD_ROTATE], shadow.cmd_seen[CMD_SIZE], shadow.results_seen);
    $display({"Peak fill %0d of %0d, %0d overflows, %0d underflows, ",
              "%0d rotations that moved data"},
             shadow.peak_fill, DEPTH, shadow.overflows, shadow.underflows,
             shadow.rotations_moved);
    if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", shadow.mismatches,
               shadow.awaited.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: draw a stall before each result beat, in stretches that are either stall-free
  // or of uniformly random stalls. Take the long hold-off when the sender asks for it.
  initial begin : receiver
    int unsigned stall;
    int unsigned stretch;
    bit          burst;
    stretch = 0;
    burst   = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      if (stretch == 0) begin
        stretch = $urandom_range(20, 60);
        burst   = ($urandom_range(0, 2) == 0);
      end
      stretch--;
      stall = burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Check every result beat, and end the run if neither side moves a beat for too long.
  // Values are sampled at the edge, before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        shadow.check_result(data_out_o, status_o, count_o);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, shadow.awaited.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
